FILE: hw/rtl/dsu_pkg.sv
// Shared types, sizes and codes for the union-find engine.
package dsu_pkg;

    // Table size and field widths
    localparam int NODES       = 256;
    localparam int NODE_W      = 8;
    localparam int SIZE_W      = 9;
    localparam int ADDR_W      = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int STEP_W      = $clog2(NODES + 1);
    localparam int CMD_W       = 2;
    localparam int IN_W        = 16;
    localparam int OUT_W       = 24;
    localparam int OUT_PAD_W   = OUT_W - NODE_W - SIZE_W - 1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [SIZE_W-1:0] count_t;

    localparam count_t SIZE_ONE = count_t'(1);
    localparam count_t SIZE_SAT = '1;

    // Command codes as they arrive on the bus
    localparam logic [CMD_W-1:0] CMD_MAKE_SET = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIND     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_UNION    = 2'd2;

    // Decoded operation handed to the back end
    typedef enum logic [1:0] {
        OP_MAKE,
        OP_FIND,
        OP_UNION,
        OP_IGNORE
    } op_t;

    typedef struct packed {
        op_t   op;
        node_t node_a;
        node_t node_b;
    } cmd_t;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAKE,
        ST_WALK_RD,
        ST_WALK,
        ST_COMP_RD,
        ST_COMP_WR,
        ST_CNT_A,
        ST_CNT_B,
        ST_MERGE,
        ST_SIZE_RD,
        ST_SIZE,
        ST_DONE
    } state_t;

endpackage

FILE: hw/rtl/dsu_ram.sv
// Generic single-port RAM with registered read data.
module dsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One access per cycle: write, or registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata <= mem[addr];
        end
    end

endmodule

FILE: hw/rtl/dsu_front.sv
// Front end: takes command beats, decodes them and queues them for the back end.
module dsu_front
    import dsu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // node_a, node_b
    input  logic [CMD_W-1:0]  s_tuser,   // command
    output cmd_t              head,
    output logic              head_valid,
    input  logic              pop
);

    cmd_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    cmd_t              cmd_in;
    logic              a_ok;
    logic              b_ok;
    logic              push;

    // Decode and range-check the operands
    always_comb
    begin
        cmd_in.node_a = s_tdata[NODE_W-1:0];
        cmd_in.node_b = s_tdata[2*NODE_W-1:NODE_W];
        a_ok = (32'(cmd_in.node_a) < 32'(NODES));
        b_ok = (32'(cmd_in.node_b) < 32'(NODES));
        case (s_tuser)
            CMD_MAKE_SET: cmd_in.op = a_ok ? OP_MAKE : OP_IGNORE;
            CMD_UNION:    cmd_in.op = (a_ok && b_ok) ? OP_UNION : OP_IGNORE;
            default:      cmd_in.op = a_ok ? OP_FIND : OP_IGNORE;
        endcase
    end

    assign s_tready   = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign push       = s_tvalid && s_tready;
    assign head_valid = (cnt_reg != '0);
    assign head       = q_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    // Queue pointers and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

FILE: hw/rtl/dsu_back.sv
// Back end: sequencer that walks, compresses and links over the parent and size tables.
module dsu_back
    import dsu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             head,
    input  logic             head_valid,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // root, set_size, merged
);

    state_t            state_reg;
    state_t            state_next;
    op_t               op_reg;
    node_t             a_reg;
    node_t             b_reg;
    logic              phase_reg;
    node_t             cur_reg;
    node_t             start_reg;
    node_t             c_reg;
    node_t             root_reg;
    node_t             ra_reg;
    count_t            sa_reg;
    logic [STEP_W-1:0] steps_reg;
    node_t             res_root_reg;
    count_t            res_size_reg;
    logic              res_merged_reg;
    logic              m_tvalid_reg;
    node_t             out_root_reg;
    count_t            out_size_reg;
    logic              out_merged_reg;

    logic [ADDR_W-1:0] p_addr;
    logic              p_we;
    node_t             p_wd;
    node_t             p_rd;
    logic [ADDR_W-1:0] c_addr;
    logic              c_we;
    count_t            c_wd;
    count_t            c_rd;

    logic              out_free;
    logic              p_is_root;
    logic              walk_end;
    node_t             walk_root;
    logic              comp_end;
    logic [SIZE_W:0]   sum;
    count_t            sum_sat;
    logic              a_small;
    node_t             win;
    node_t             lose;

    dsu_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODES)
    ) u_parent_ram (
        .clk   (clk),
        .addr  (p_addr),
        .we    (p_we),
        .wdata (p_wd),
        .rdata (p_rd)
    );

    dsu_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (NODES)
    ) u_count_ram (
        .clk   (clk),
        .addr  (c_addr),
        .we    (c_we),
        .wdata (c_wd),
        .rdata (c_rd)
    );

    // Walk, compression and link decisions
    assign out_free  = !m_tvalid_reg || m_tready;
    assign p_is_root = (p_rd == cur_reg);
    assign walk_end  = p_is_root || (steps_reg == STEP_W'(NODES - 1));
    assign walk_root = p_is_root ? cur_reg : p_rd;
    assign comp_end  = (c_reg == root_reg) || (steps_reg == STEP_W'(NODES));
    assign sum       = {1'b0, sa_reg} + {1'b0, c_rd};
    assign sum_sat   = sum[SIZE_W] ? SIZE_SAT : sum[SIZE_W-1:0];
    assign a_small   = (sa_reg < c_rd);
    assign win       = a_small ? root_reg : ra_reg;
    assign lose      = a_small ? ra_reg : root_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    case (head.op)
                        OP_MAKE:   state_next = ST_MAKE;
                        OP_IGNORE: state_next = ST_DONE;
                        default:   state_next = ST_WALK_RD;
                    endcase
                end
            end
            ST_MAKE:    state_next = ST_DONE;
            ST_WALK_RD: state_next = ST_WALK;
            ST_WALK:
            begin
                if (walk_end)
                begin
                    state_next = ST_COMP_RD;
                end
            end
            ST_COMP_RD:
            begin
                if (!comp_end)
                begin
                    state_next = ST_COMP_WR;
                end
                else if (op_reg == OP_UNION && !phase_reg)
                begin
                    state_next = ST_WALK_RD;
                end
                else if (op_reg == OP_UNION && ra_reg != root_reg)
                begin
                    state_next = ST_CNT_A;
                end
                else
                begin
                    state_next = ST_SIZE_RD;
                end
            end
            ST_COMP_WR: state_next = ST_COMP_RD;
            ST_CNT_A:   state_next = ST_CNT_B;
            ST_CNT_B:   state_next = ST_MERGE;
            ST_MERGE:   state_next = ST_DONE;
            ST_SIZE_RD: state_next = ST_SIZE;
            ST_SIZE:    state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Table ports and queue pop
    always_comb
    begin
        pop    = 1'b0;
        p_addr = '0;
        p_we   = 1'b0;
        p_wd   = '0;
        c_addr = '0;
        c_we   = 1'b0;
        c_wd   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                pop = head_valid;
            end
            ST_MAKE:
            begin
                p_addr = a_reg[ADDR_W-1:0];
                p_we   = 1'b1;
                p_wd   = a_reg;
                c_addr = a_reg[ADDR_W-1:0];
                c_we   = 1'b1;
                c_wd   = SIZE_ONE;
            end
            ST_WALK_RD:
            begin
                p_addr = cur_reg[ADDR_W-1:0];
            end
            ST_WALK:
            begin
                p_addr = p_rd[ADDR_W-1:0];
            end
            ST_COMP_RD:
            begin
                p_addr = c_reg[ADDR_W-1:0];
            end
            ST_COMP_WR:
            begin
                p_addr = c_reg[ADDR_W-1:0];
                p_we   = 1'b1;
                p_wd   = root_reg;
            end
            ST_CNT_A:
            begin
                c_addr = ra_reg[ADDR_W-1:0];
            end
            ST_CNT_B:
            begin
                c_addr = root_reg[ADDR_W-1:0];
            end
            ST_MERGE:
            begin
                p_addr = lose[ADDR_W-1:0];
                p_we   = 1'b1;
                p_wd   = win;
                c_addr = win[ADDR_W-1:0];
                c_we   = 1'b1;
                c_wd   = sum_sat;
            end
            ST_SIZE_RD:
            begin
                c_addr = root_reg[ADDR_W-1:0];
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    op_reg         <= head.op;
                    a_reg          <= head.node_a;
                    b_reg          <= head.node_b;
                    phase_reg      <= 1'b0;
                    cur_reg        <= head.node_a;
                    start_reg      <= head.node_a;
                    steps_reg      <= '0;
                    res_root_reg   <= head.node_a;
                    res_size_reg   <= SIZE_ONE;
                    res_merged_reg <= 1'b0;
                end
            end
            ST_WALK:
            begin
                if (walk_end)
                begin
                    root_reg  <= walk_root;
                    c_reg     <= start_reg;
                    steps_reg <= '0;
                end
                else
                begin
                    cur_reg   <= p_rd;
                    steps_reg <= steps_reg + STEP_W'(1);
                end
            end
            ST_COMP_RD:
            begin
                // first root found: start the walk from the second operand
                if (comp_end && op_reg == OP_UNION && !phase_reg)
                begin
                    ra_reg    <= root_reg;
                    phase_reg <= 1'b1;
                    cur_reg   <= b_reg;
                    start_reg <= b_reg;
                    steps_reg <= '0;
                end
            end
            ST_COMP_WR:
            begin
                c_reg     <= p_rd;
                steps_reg <= steps_reg + STEP_W'(1);
            end
            ST_CNT_B:
            begin
                sa_reg <= c_rd;
            end
            ST_MERGE:
            begin
                res_root_reg   <= win;
                res_size_reg   <= sum_sat;
                res_merged_reg <= 1'b1;
            end
            ST_SIZE:
            begin
                res_root_reg   <= root_reg;
                res_size_reg   <= c_rd;
                res_merged_reg <= 1'b0;
            end
            default:
            begin
                res_merged_reg <= res_merged_reg;
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            out_root_reg   <= res_root_reg;
            out_size_reg   <= res_size_reg;
            out_merged_reg <= res_merged_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_merged_reg, out_size_reg, out_root_reg};

endmodule

FILE: hw/rtl/disjoint_set_union_engine.sv
// Top level of the union-find engine with path compression and union by size.
//
// Union-find engine over a table of 256 nodes. Each command beat on the slave
// side (make-set, find or union) yields exactly one result beat on the master
// side with the root of node_a's set, the size of that set and, for union, a
// merged flag. Commands enter a two-deep queue and are carried out one at a
// time by a sequencer over single-port parent and size tables, so the
// single read/write port of the parent table sets the time per command:
// make-set writes both tables once; find walks from node_a to its root and
// then rewrites each node on that path to point at the root; union does that
// walk for each operand and then links the two roots. A finished result waits
// in an output register while the next commands are queued and started.
// A node must be made with make-set before any find or union reaches it.
module disjoint_set_union_engine
    import dsu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // [7:0] node_a, [15:8] node_b
    input  logic [CMD_W-1:0] s_tuser,   // [1:0] command
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // [7:0] root, [16:8] set_size, [17] merged, zero pad
);

    cmd_t head;
    logic head_valid;
    logic pop;

    dsu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    dsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

FILE: hw/rtl/dsu_checker.sv
// Port-level checks for the union-find engine, bound to the top level.
module dsu_checker
    import dsu_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    logic [2:0] pending_reg;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    // Commands taken but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_beat && !out_beat)
        begin
            pending_reg <= pending_reg + 3'd1;
        end
        else if (out_beat && !in_beat)
        begin
            pending_reg <= pending_reg - 3'd1;
        end
    end

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // No result without a command behind it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != 3'd0)
        else $error("result beat with no command pending");

    // Input only backs up once the queue is full
    a_queue_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> pending_reg >= 3'd2)
        else $error("input stalled with queue not full");

    // Every set holds at least one node
    a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[16:8] != 9'd0)
        else $error("result set size is zero");

    // A merge leaves at least two nodes
    a_merge_size: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[17] |-> m_tdata[16:8] >= 9'd2)
        else $error("merged set smaller than two");

endmodule

bind disjoint_set_union_engine dsu_checker u_dsu_checker (.*);

FILE: bench/tb_top.sv
// Self-checking bench for the union-find engine: directed table, random traffic, saturation run.
module tb_top;
    import dsu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // A command code of three is decoded as a find
    localparam logic [CMD_W-1:0] CMD_FIND_ALT = 2'd3;
    localparam int DIRECTED_ROWS = 23;
    localparam int TOTAL_BEATS   = 1750;
    localparam int DRAIN_CYCLES  = 60;

    typedef struct packed {
        node_t  root;
        count_t size;
        logic   merged;
    } set_answer_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        node_t            a;
        node_t            b;
        logic             typed;
        set_answer_t      answer;
    } cmd_row_t;

    localparam set_answer_t NO_ANSWER = '0;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;     // [7:0] node_a, [15:8] node_b
    logic [CMD_W-1:0] s_tuser = '0;     // [1:0] command
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;          // [7:0] root, [16:8] set_size, [17] merged

    // Shadow copy of the node table
    node_t  link_of [NODES];
    count_t size_of [NODES];

    // Nodes already made, so no command ever reads an unwritten entry
    bit     is_made [NODES];
    node_t  made_nodes [$];

    set_answer_t pending_answers [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors = 0;
    int beats_sent = 0;
    int n_make = 0;
    int n_find = 0;
    int n_union = 0;
    int n_merged = 0;
    int n_saturated = 0;

    // Hand-checked opening sequence; untyped rows go to the predictor
    cmd_row_t directed_rows [DIRECTED_ROWS] = '{
        '{CMD_MAKE_SET, 8'd0,   8'd0,   1'b1, '{8'd0,   9'd1, 1'b0}},
        '{CMD_MAKE_SET, 8'd255, 8'hFF,  1'b1, '{8'd255, 9'd1, 1'b0}},
        '{CMD_UNION,    8'd0,   8'd255, 1'b1, '{8'd0,   9'd2, 1'b1}},
        '{CMD_UNION,    8'd255, 8'd0,   1'b1, '{8'd0,   9'd2, 1'b0}},
        '{CMD_FIND,     8'd255, 8'hAA,  1'b1, '{8'd0,   9'd2, 1'b0}},
        '{CMD_FIND_ALT, 8'd255, 8'h55,  1'b1, '{8'd0,   9'd2, 1'b0}},
        '{CMD_MAKE_SET, 8'd1,   8'd0,   1'b1, '{8'd1,   9'd1, 1'b0}},
        '{CMD_UNION,    8'd1,   8'd255, 1'b1, '{8'd0,   9'd3, 1'b1}},
        '{CMD_MAKE_SET, 8'd2,   8'd0,   1'b1, '{8'd2,   9'd1, 1'b0}},
        '{CMD_MAKE_SET, 8'd3,   8'd0,   1'b1, '{8'd3,   9'd1, 1'b0}},
        '{CMD_UNION,    8'd3,   8'd2,   1'b1, '{8'd3,   9'd2, 1'b1}},
        '{CMD_UNION,    8'd2,   8'd1,   1'b0, NO_ANSWER},
        '{CMD_FIND,     8'd2,   8'd0,   1'b0, NO_ANSWER},
        '{CMD_FIND,     8'd2,   8'd0,   1'b0, NO_ANSWER},
        '{CMD_MAKE_SET, 8'd3,   8'd0,   1'b1, '{8'd3,   9'd1, 1'b0}},
        '{CMD_UNION,    8'd3,   8'd0,   1'b0, NO_ANSWER},
        '{CMD_MAKE_SET, 8'd128, 8'hFF,  1'b1, '{8'd128, 9'd1, 1'b0}},
        '{CMD_MAKE_SET, 8'd127, 8'd0,   1'b1, '{8'd127, 9'd1, 1'b0}},
        '{CMD_UNION,    8'd127, 8'd128, 1'b1, '{8'd127, 9'd2, 1'b1}},
        '{CMD_UNION,    8'd128, 8'd255, 1'b0, NO_ANSWER},
        '{CMD_FIND_ALT, 8'd127, 8'hFF,  1'b0, NO_ANSWER},
        '{CMD_MAKE_SET, 8'd0,   8'd0,   1'b1, '{8'd0,   9'd1, 1'b0}},
        '{CMD_FIND,     8'd255, 8'd0,   1'b0, NO_ANSWER}
    };

    disjoint_set_union_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    // Root lookup without touching the table
    function automatic node_t peek_root(node_t x);
        node_t top;
        int    steps;
        top = x;
        steps = 0;
        while (link_of[top] != top && steps < NODES) begin
            top = link_of[top];
            steps++;
        end
        return top;
    endfunction

    // Root lookup that points every node on the path straight at the root
    function automatic node_t flatten_to_root(node_t x);
        node_t top;
        node_t cur;
        node_t nxt;
        int    steps;
        top = peek_root(x);
        cur = x;
        steps = 0;
        while (cur != top && steps < NODES) begin
            nxt = link_of[cur];
            link_of[cur] = top;
            cur = nxt;
            steps++;
        end
        return top;
    endfunction

    // Apply one command to the shadow table and return its answer
    function automatic set_answer_t apply_command(logic [CMD_W-1:0] cmd, node_t a, node_t b);
        set_answer_t ans;
        node_t       ra;
        node_t       rb;
        node_t       swap;
        int unsigned total;
        ans.root = a;
        ans.size = SIZE_ONE;
        ans.merged = 1'b0;
        if (cmd == CMD_MAKE_SET) begin
            link_of[a] = a;
            size_of[a] = SIZE_ONE;
        end else if (cmd == CMD_UNION) begin
            ra = flatten_to_root(a);
            rb = flatten_to_root(b);
            if (ra != rb) begin
                // Smaller set goes under the larger; ties keep node_a's root
                if (size_of[ra] < size_of[rb]) begin
                    swap = ra;
                    ra = rb;
                    rb = swap;
                end
                link_of[rb] = ra;
                total = size_of[ra] + size_of[rb];
                size_of[ra] = (total > SIZE_SAT) ? SIZE_SAT : count_t'(total);
                ans.merged = 1'b1;
            end
            ans.root = ra;
            ans.size = size_of[ra];
        end else begin
            ans.root = flatten_to_root(a);
            ans.size = size_of[ans.root];
        end
        return ans;
    endfunction

    // Send one command beat, then record what it must return
    task automatic issue_command(logic [CMD_W-1:0] cmd, node_t a, node_t b,
                                 logic typed, set_answer_t fixed);
        set_answer_t ans;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tuser  <= cmd;
        do @(posedge clk); while (!s_tready);
        ans = apply_command(cmd, a, b);
        pending_answers.push_back(typed ? fixed : ans);
        beats_sent++;
        if (cmd == CMD_MAKE_SET) begin
            n_make++;
            if (!is_made[a]) begin
                is_made[a] = 1'b1;
                made_nodes.push_back(a);
            end
        end else if (cmd == CMD_UNION) begin
            n_union++;
        end else begin
            n_find++;
        end
        if (ans.merged)
            n_merged++;
        if (ans.size == SIZE_SAT)
            n_saturated++;
    endtask

    function automatic node_t any_made();
        return made_nodes[$urandom_range(0, made_nodes.size() - 1)];
    endfunction

    // Random command; find and union use made nodes, node_b is free noise outside union
    task automatic random_command();
        int               pick;
        int               make_pct;
        node_t            a;
        node_t            b;
        logic [CMD_W-1:0] cmd;
        pick = $urandom_range(0, 99);
        make_pct = (made_nodes.size() < 64) ? 40 : 12;
        a = node_t'($urandom);
        b = node_t'($urandom);
        if (made_nodes.size() < 2 || pick < make_pct) begin
            cmd = CMD_MAKE_SET;
        end else begin
            a = any_made();
            if (pick < 60) begin
                cmd = CMD_UNION;
                b = any_made();
            end else if (pick < 92) begin
                cmd = CMD_FIND;
            end else begin
                cmd = CMD_FIND_ALT;
            end
        end
        issue_command(cmd, a, b, 1'b0, NO_ANSWER);
    endtask

    // Re-root a node and merge it into the biggest set until the set has stayed saturated for extra_pairs rounds
    task automatic grow_to_saturation(int extra_pairs);
        node_t big;
        node_t x;
        int    left;
        big = peek_root(made_nodes[0]);
        foreach (made_nodes[i])
            if (size_of[peek_root(made_nodes[i])] > size_of[big])
                big = peek_root(made_nodes[i]);
        left = extra_pairs;
        while (left > 0) begin
            do x = any_made(); while (x == big);
            issue_command(CMD_MAKE_SET, x, node_t'($urandom), 1'b0, NO_ANSWER);
            if ($urandom_range(0, 1))
                issue_command(CMD_UNION, x, big, 1'b0, NO_ANSWER);
            else
                issue_command(CMD_UNION, big, x, 1'b0, NO_ANSWER);
            if ($urandom_range(0, 3) == 0)
                issue_command(CMD_FIND, any_made(), node_t'($urandom), 1'b0, NO_ANSWER);
            big = peek_root(big);
            if (size_of[big] == SIZE_SAT)
                left--;
        end
    endtask

    // Receiver back-pressure
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Result checker
    always @(posedge clk) begin
        set_answer_t got;
        set_answer_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got.root   = m_tdata[NODE_W-1:0];
            got.size   = m_tdata[NODE_W +: SIZE_W];
            got.merged = m_tdata[NODE_W + SIZE_W];
            if (pending_answers.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat: root %0d size %0d merged %0b",
                         $time, got.root, got.size, got.merged);
            end else begin
                want = pending_answers.pop_front();
                if (got.root !== want.root || got.size !== want.size
                        || got.merged !== want.merged) begin
                    errors++;
                    $display("%0t: mismatch: expected root %0d size %0d merged %0b, got root %0d size %0d merged %0b",
                             $time, want.root, want.size, want.merged,
                             got.root, got.size, got.merged);
                end
            end
        end
    end

    // Stimulus and end of run
    initial begin
        foreach (link_of[i]) begin
            link_of[i] = '0;
            size_of[i] = '0;
            is_made[i] = 1'b0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender mostly busy, receiver mostly stalled
        send_idle_pct = 12;
        recv_idle_pct = 73;
        foreach (directed_rows[i])
            issue_command(directed_rows[i].cmd, directed_rows[i].a, directed_rows[i].b,
                          directed_rows[i].typed, directed_rows[i].answer);
        repeat (450) random_command();

        // Sender mostly idle, receiver mostly ready
        send_idle_pct = 73;
        recv_idle_pct = 12;
        repeat (450) random_command();

        // Full rate: drive one set to the size ceiling, then plain traffic
        send_idle_pct = 0;
        recv_idle_pct = 0;
        grow_to_saturation(12);
        while (beats_sent < TOTAL_BEATS)
            random_command();
        s_tvalid <= 1'b0;

        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_answers.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, pending_answers.size());
        end

        $display("Ran %0d commands: %0d make-set, %0d find, %0d union (%0d merges).",
                 beats_sent, n_make, n_find, n_union, n_merged);
        $display("%0d answers hit the saturated size; %0d nodes made; %0d mismatches.",
                 n_saturated, made_nodes.size(), errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
